FILE: src/rbcm_pkg.sv
// ----------------------------------------------------------------------------
// rbcm_pkg
// Shared widths, operation/status codes and helpers for the ring buffer
// chunk manager.
// ----------------------------------------------------------------------------
`default_nettype none

package rbcm_pkg;

    // Position and count widths
    localparam int SIZE_BITS = 16;
    localparam int POS_W     = SIZE_BITS;
    localparam int CNT_W     = SIZE_BITS + 1;

    // Word field widths
    localparam int OP_W     = 3;
    localparam int SIDE_W   = 2;
    localparam int LEN_W    = 17;
    localparam int OFF_W    = 17;
    localparam int STATUS_W = 2;
    localparam int REG_W    = 16;

    // Config port
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] REG_BUF_SIZE   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_EXTRA_SIZE = 2'd1;
    localparam logic [REG_W-1:0]     BUF_SIZE_RST   = 16'd4096;
    localparam logic [REG_W-1:0]     EXTRA_SIZE_RST = 16'd0;

    // Modulo unit: dividend width and step counter
    localparam int DIV_W     = SIZE_BITS + 2;
    localparam int DIV_STEPS = DIV_W;
    localparam int STEP_W    = $clog2(DIV_STEPS);

    localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

    // Operation codes
    localparam logic [OP_W-1:0] OP_GET   = 3'd0;
    localparam logic [OP_W-1:0] OP_UNGET = 3'd1;
    localparam logic [OP_W-1:0] OP_PUT   = 3'd2;
    localparam logic [OP_W-1:0] OP_QUERY = 3'd3;
    localparam logic [OP_W-1:0] OP_RESET = 3'd4;

    // Side codes
    localparam logic [SIDE_W-1:0] SIDE_ROOM = 2'd0;
    localparam logic [SIDE_W-1:0] SIDE_DATA = 2'd1;

    // Status codes
    localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] ST_BAD_SIDE = 2'd1;
    localparam logic [STATUS_W-1:0] ST_MISMATCH = 2'd2;

    // Result word
    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [LEN_W-1:0]    grant_len;
        logic [POS_W-1:0]    grant_offset;
        logic [CNT_W-1:0]    level;
        logic                exact_fit;
        logic [REG_W-1:0]    mirror_len;
        logic [LEN_W-1:0]    wrap_len;
        logic [OFF_W-1:0]    wrap_src;
    } result_t;

    // Saturating count add
    function automatic logic [CNT_W-1:0] sat_add(input logic [CNT_W-1:0] cnt,
                                                 input logic [LEN_W-1:0] len);
        logic [CNT_W:0] sum;
        sum = {1'b0, cnt} + (CNT_W+1)'(len);
        return sum[CNT_W] ? CNT_MAX : sum[CNT_W-1:0];
    endfunction

endpackage

`default_nettype wire

FILE: src/rbcm_if.sv
// ----------------------------------------------------------------------------
// rbcm channel interfaces
// Request, response and config channels, each valid/ready.
// ----------------------------------------------------------------------------
`default_nettype none

interface rbcm_req_if;
    logic                           valid;
    logic                           ready;
    logic [rbcm_pkg::OP_W-1:0]      op;
    logic [rbcm_pkg::SIDE_W-1:0]    side;
    logic [rbcm_pkg::LEN_W-1:0]     length;
    logic [rbcm_pkg::OFF_W-1:0]     chunk_offset;
    logic                           chunk_present;

    modport source (output valid, op, side, length, chunk_offset, chunk_present,
                    input ready);
    modport sink   (input valid, op, side, length, chunk_offset, chunk_present,
                    output ready);
endinterface

interface rbcm_rsp_if;
    logic                           valid;
    logic                           ready;
    logic [rbcm_pkg::STATUS_W-1:0]  status;
    logic [rbcm_pkg::LEN_W-1:0]     grant_len;
    logic [rbcm_pkg::POS_W-1:0]     grant_offset;
    logic [rbcm_pkg::CNT_W-1:0]     level;
    logic                           exact_fit;
    logic [rbcm_pkg::REG_W-1:0]     mirror_len;
    logic [rbcm_pkg::LEN_W-1:0]     wrap_len;
    logic [rbcm_pkg::OFF_W-1:0]     wrap_src;

    modport source (output valid, status, grant_len, grant_offset, level, exact_fit,
                    mirror_len, wrap_len, wrap_src, input ready);
    modport sink   (input valid, status, grant_len, grant_offset, level, exact_fit,
                    mirror_len, wrap_len, wrap_src, output ready);
endinterface

interface rbcm_cfg_if;
    logic                           valid;
    logic                           ready;
    logic [rbcm_pkg::CFG_IDX_W-1:0] index;
    logic [rbcm_pkg::REG_W-1:0]     data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

FILE: src/ring_buffer_chunk_manager.sv
// ----------------------------------------------------------------------------
// ring_buffer_chunk_manager
// Position and count bookkeeping for a two-sided ring buffer with an extra
// area past the buffer end.
// ----------------------------------------------------------------------------
// One request word is handled at a time; req.ready is high only while the
// sequencer is idle. Put, query, reset and rejected words go through the
// calc and done states to the output register; a get or an unget also runs
// a shared bit-serial modulo unit that reduces an 18-bit value by buf_size
// (once for a get, three times for an unget). The response sits in an
// output register, so the next request is taken while the previous response
// waits. Config writes are always accepted and must only be issued while no
// request is in flight.
`default_nettype none

module ring_buffer_chunk_manager
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    rbcm_req_if.sink    req,
    rbcm_rsp_if.source  rsp,
    rbcm_cfg_if.sink    cfg
);
    import rbcm_pkg::*;

    // Sequencer states
    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_CALC = 3'd1;
    localparam logic [2:0] S_MOD  = 3'd2;
    localparam logic [2:0] S_NEXT = 3'd3;
    localparam logic [2:0] S_DONE = 3'd4;

    // Modulo pass in flight
    localparam logic [1:0] P_GET  = 2'd0;
    localparam logic [1:0] P_LM   = 2'd1;
    localparam logic [1:0] P_BACK = 2'd2;
    localparam logic [1:0] P_OFF  = 2'd3;

    // Control registers
    logic [2:0]        state_reg, state_next;
    logic [1:0]        pass_reg, pass_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic              out_valid_reg, out_valid_next;
    logic [REG_W-1:0]  buf_size_reg, buf_size_next;
    logic [REG_W-1:0]  extra_size_reg, extra_size_next;
    logic [POS_W-1:0]  write_pos_reg, write_pos_next;
    logic [POS_W-1:0]  read_pos_reg, read_pos_next;
    logic [CNT_W-1:0]  free_room_reg, free_room_next;
    logic [CNT_W-1:0]  data_count_reg, data_count_next;

    // Datapath registers
    logic [OP_W-1:0]   op_reg, op_next;
    logic [SIDE_W-1:0] side_reg, side_next;
    logic [LEN_W-1:0]  len_reg, len_next;
    logic [OFF_W-1:0]  off_reg, off_next;
    logic              present_reg, present_next;
    logic [DIV_W-1:0]  div_reg, div_next;
    logic [POS_W-1:0]  rem_reg, rem_next;
    logic [POS_W-1:0]  back_reg, back_next;
    result_t           res_reg, res_next;
    result_t           out_reg, out_next;

    // Combinational helpers
    logic [POS_W-1:0]  sel_pos;
    logic [CNT_W-1:0]  sel_cnt;
    logic [CNT_W-1:0]  span_tot;
    logic [CNT_W-1:0]  span;
    logic [CNT_W-1:0]  grant_a;
    logic [CNT_W-1:0]  grant;
    logic [POS_W:0]    rem_trial;
    logic [POS_W-1:0]  rem_eff;
    logic [DIV_W-1:0]  put_end;
    logic [DIV_W-1:0]  wrap_w;
    logic [REG_W-1:0]  mirror_m;
    logic              chunk_live;
    logic              side_bad;
    logic              load_out;

    // Handshakes
    assign req.ready = (state_reg == S_IDLE);
    assign cfg.ready = 1'b1;
    assign rsp.valid = out_valid_reg;
    assign rsp.status       = out_reg.status;
    assign rsp.grant_len    = out_reg.grant_len;
    assign rsp.grant_offset = out_reg.grant_offset;
    assign rsp.level        = out_reg.level;
    assign rsp.exact_fit    = out_reg.exact_fit;
    assign rsp.mirror_len   = out_reg.mirror_len;
    assign rsp.wrap_len     = out_reg.wrap_len;
    assign rsp.wrap_src     = out_reg.wrap_src;

    // Selected side
    assign sel_pos    = side_reg[0] ? read_pos_reg : write_pos_reg;
    assign sel_cnt    = side_reg[0] ? data_count_reg : free_room_reg;
    assign side_bad   = (side_reg != SIDE_ROOM) && (side_reg != SIDE_DATA);
    assign chunk_live = (len_reg != '0) && present_reg;

    // Grantable length: min(count, span to end of extra area, request)
    assign span_tot = CNT_W'(buf_size_reg) + CNT_W'(extra_size_reg);
    assign span     = (span_tot > CNT_W'(sel_pos)) ? span_tot - CNT_W'(sel_pos) : '0;
    assign grant_a  = (sel_cnt < span) ? sel_cnt : span;
    assign grant    = (grant_a < CNT_W'(len_reg)) ? grant_a : CNT_W'(len_reg);

    // Data put mirror copies
    assign put_end  = DIV_W'(off_reg) + DIV_W'(len_reg);
    assign mirror_m = extra_size_reg - off_reg[REG_W-1:0];
    assign wrap_w   = (DIV_W'(len_reg) < put_end - DIV_W'(buf_size_reg))
                      ? DIV_W'(len_reg) : put_end - DIV_W'(buf_size_reg);

    // Shared modulo unit: one restoring step per cycle
    assign rem_trial = {rem_reg, div_reg[DIV_W-1]};
    assign rem_eff   = (buf_size_reg == '0) ? '0 : rem_reg;

    assign load_out = (state_reg == S_DONE) && (!out_valid_reg || rsp.ready);

    // Next-state logic
    always_comb
    begin
        state_next      = state_reg;
        pass_next       = pass_reg;
        step_next       = step_reg;
        out_valid_next  = out_valid_reg;
        buf_size_next   = buf_size_reg;
        extra_size_next = extra_size_reg;
        write_pos_next  = write_pos_reg;
        read_pos_next   = read_pos_reg;
        free_room_next  = free_room_reg;
        data_count_next = data_count_reg;
        op_next         = op_reg;
        side_next       = side_reg;
        len_next        = len_reg;
        off_next        = off_reg;
        present_next    = present_reg;
        div_next        = div_reg;
        rem_next        = rem_reg;
        back_next       = back_reg;
        res_next        = res_reg;
        out_next        = out_reg;

        // Config writes
        if (cfg.valid)
        begin
            if (cfg.index == REG_BUF_SIZE)
            begin
                buf_size_next = cfg.data;
            end
            else if (cfg.index == REG_EXTRA_SIZE)
            begin
                extra_size_next = cfg.data;
            end
        end

        // Response register
        if (rsp.valid && rsp.ready)
        begin
            out_valid_next = 1'b0;
        end
        if (load_out)
        begin
            out_next       = res_reg;
            out_valid_next = 1'b1;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (req.valid)
                begin
                    op_next      = req.op;
                    side_next    = req.side;
                    len_next     = req.length;
                    off_next     = req.chunk_offset;
                    present_next = req.chunk_present;
                    res_next     = '0;
                    state_next   = S_CALC;
                end
            end

            S_CALC:
            begin
                state_next = S_DONE;
                rem_next   = '0;
                step_next  = '0;
                case (op_reg)
                    OP_GET:
                    begin
                        if (side_bad)
                        begin
                            res_next.status = ST_BAD_SIDE;
                        end
                        else
                        begin
                            res_next.grant_len    = grant;
                            res_next.grant_offset = sel_pos;
                            if (side_reg[0])
                            begin
                                data_count_next = data_count_reg - grant;
                            end
                            else
                            begin
                                free_room_next = free_room_reg - grant;
                            end
                            div_next   = DIV_W'(sel_pos) + DIV_W'(grant);
                            pass_next  = P_GET;
                            state_next = S_MOD;
                        end
                    end

                    OP_UNGET:
                    begin
                        if (chunk_live)
                        begin
                            if (side_bad)
                            begin
                                res_next.status = ST_BAD_SIDE;
                            end
                            else
                            begin
                                div_next   = DIV_W'(len_reg);
                                pass_next  = P_LM;
                                state_next = S_MOD;
                            end
                        end
                    end

                    OP_PUT:
                    begin
                        if (chunk_live)
                        begin
                            if (side_reg == SIDE_DATA)
                            begin
                                data_count_next = sat_add(data_count_reg, len_reg);
                                if (off_reg < OFF_W'(extra_size_reg))
                                begin
                                    res_next.mirror_len =
                                        (len_reg < LEN_W'(mirror_m))
                                        ? len_reg[REG_W-1:0] : mirror_m;
                                end
                                if (put_end > DIV_W'(buf_size_reg))
                                begin
                                    res_next.wrap_len = wrap_w[LEN_W-1:0];
                                    res_next.wrap_src = OFF_W'(put_end - wrap_w);
                                end
                            end
                            else if (side_reg == SIDE_ROOM)
                            begin
                                free_room_next = sat_add(free_room_reg, len_reg);
                            end
                            else
                            begin
                                res_next.status = ST_BAD_SIDE;
                            end
                        end
                    end

                    OP_QUERY:
                    begin
                        if (side_bad)
                        begin
                            res_next.status    = ST_BAD_SIDE;
                            res_next.exact_fit = (len_reg == '0);
                        end
                        else
                        begin
                            res_next.grant_len = grant;
                            res_next.level     = sel_cnt;
                            res_next.exact_fit = (grant == CNT_W'(len_reg));
                        end
                    end

                    OP_RESET:
                    begin
                        write_pos_next  = '0;
                        read_pos_next   = '0;
                        free_room_next  = CNT_W'(buf_size_reg);
                        data_count_next = '0;
                    end

                    default:
                    begin
                        // unknown op: no change
                    end
                endcase
            end

            S_MOD:
            begin
                if (rem_trial >= (POS_W+1)'(buf_size_reg))
                begin
                    rem_next = POS_W'(rem_trial - (POS_W+1)'(buf_size_reg));
                end
                else
                begin
                    rem_next = rem_trial[POS_W-1:0];
                end
                div_next  = div_reg << 1;
                step_next = step_reg + 1'b1;
                if (step_reg == STEP_W'(DIV_STEPS - 1))
                begin
                    state_next = S_NEXT;
                end
            end

            S_NEXT:
            begin
                rem_next   = '0;
                step_next  = '0;
                state_next = S_MOD;
                case (pass_reg)
                    P_GET:
                    begin
                        if (side_reg[0])
                        begin
                            read_pos_next = rem_eff;
                        end
                        else
                        begin
                            write_pos_next = rem_eff;
                        end
                        state_next = S_DONE;
                    end

                    // Rewind: pos + size - (len mod size)
                    P_LM:
                    begin
                        div_next  = DIV_W'(sel_pos) + DIV_W'(buf_size_reg)
                                    - DIV_W'(rem_eff);
                        pass_next = P_BACK;
                    end

                    P_BACK:
                    begin
                        back_next = rem_eff;
                        div_next  = DIV_W'(off_reg);
                        pass_next = P_OFF;
                    end

                    P_OFF:
                    begin
                        if (back_reg == rem_eff)
                        begin
                            if (side_reg[0])
                            begin
                                read_pos_next   = back_reg;
                                data_count_next = sat_add(data_count_reg, len_reg);
                            end
                            else
                            begin
                                write_pos_next = back_reg;
                                free_room_next = sat_add(free_room_reg, len_reg);
                            end
                        end
                        else
                        begin
                            res_next.status = ST_MISMATCH;
                        end
                        state_next = S_DONE;
                    end

                    default:
                    begin
                        state_next = S_DONE;
                    end
                endcase
            end

            S_DONE:
            begin
                if (load_out)
                begin
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            pass_reg       <= P_GET;
            step_reg       <= '0;
            out_valid_reg  <= 1'b0;
            buf_size_reg   <= BUF_SIZE_RST;
            extra_size_reg <= EXTRA_SIZE_RST;
            write_pos_reg  <= '0;
            read_pos_reg   <= '0;
            free_room_reg  <= CNT_W'(BUF_SIZE_RST);
            data_count_reg <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            pass_reg       <= pass_next;
            step_reg       <= step_next;
            out_valid_reg  <= out_valid_next;
            buf_size_reg   <= buf_size_next;
            extra_size_reg <= extra_size_next;
            write_pos_reg  <= write_pos_next;
            read_pos_reg   <= read_pos_next;
            free_room_reg  <= free_room_next;
            data_count_reg <= data_count_next;
        end
    end

    // Payload and datapath
    always_ff @(posedge clk)
    begin
        op_reg      <= op_next;
        side_reg    <= side_next;
        len_reg     <= len_next;
        off_reg     <= off_next;
        present_reg <= present_next;
        div_reg     <= div_next;
        rem_reg     <= rem_next;
        back_reg    <= back_next;
        res_reg     <= res_next;
        out_reg     <= out_next;
    end

`ifndef NO_ASSERTIONS
    // A request is taken only by an idle sequencer, which then goes busy
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (req.valid && req.ready) |=> !req.ready)
        else $error("sequencer still ready after taking a request");

    // A finished modulo pass leaves a remainder below the modulus
    a_rem_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_NEXT && buf_size_reg != '0) |-> (rem_reg < buf_size_reg))
        else $error("modulo remainder out of range");

    // A finished result waits while the response register is still occupied
    a_hold_result: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DONE && rsp.valid && !rsp.ready) |=> (state_reg == S_DONE))
        else $error("result overwrote a pending response word");
`endif

endmodule

`default_nettype wire
